// File: hw/rtl/e80b64_pkg.sv
package e80b64_pkg;

   localparam int SIG_W = 64;
   localparam int SE_W  = 16;
   localparam int DBL_W = 64;

   localparam logic [14:0] EXP_TOP     = 15'h7FFF;
   localparam int          EXT_BIAS    = 16383;
   localparam int          DBL_BIAS    = 1023;
   localparam int          DBL_EMIN    = -1022;
   localparam int          DBL_EMAX    = 1023;
   localparam int          SUB_OFFSET  = 1011;
   localparam logic [62:0] INF_MAG     = 63'h7FF0000000000000;

   function automatic logic [5:0] lead_zeros(input logic [SIG_W-1:0] m);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < SIG_W; i++) begin
         if (m[i]) begin
            n = 6'(SIG_W - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

// File: hw/rtl/extended80_to_binary64.sv
// Path: an accepted word goes into the input register, then through the conversion pass into
// the result register, where rsp_valid rises; rsp_stall can hold it in the input register.
// Throughput: one word per cycle while rsp_stall is low; the single conversion pass between the
// two registers sets this figure, and one more word is taken into the input
// register while a result waits.
// Reset: synchronous, active high; clears both valid flags, payload is not reset.
module extended80_to_binary64 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_significand,
   input  logic [15:0] req_sign_exponent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_double_bits
);

   logic        in_valid_ff, in_valid_in;
   logic [63:0] sig_ff;
   logic [15:0] se_ff;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] dbl_ff, dbl_in;
   logic        move;

   logic [5:0]          lz;
   logic [63:0]         norm;
   logic signed [17:0]  top;
   logic signed [17:0]  sh_full;
   logic [6:0]          sh;
   logic [127:0]        wide;
   logic                n_inc;
   logic [53:0]         n_r;
   logic signed [17:0]  biased;
   logic                s_inc;
   logic [63:0]         s_r;
   logic                sgn;

   assign move        = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !move;
   assign in_valid_in = req_valid ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign out_valid_in = move ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   always_comb begin
      sgn  = se_ff[15];
      lz   = e80b64_pkg::lead_zeros(sig_ff);
      norm = sig_ff << lz;
      top  = 18'(signed'({3'b000, se_ff[14:0]})) - 18'(signed'({12'd0, lz}))
             - 18'(e80b64_pkg::EXT_BIAS);

      // normal path: keep 53 bits, round to nearest even on guard, sticky and lsb
      n_inc  = norm[10] && ((|norm[9:0]) || norm[11]);
      n_r    = {1'b0, norm[63:11]} + 54'(n_inc);
      biased = top + 18'(e80b64_pkg::DBL_BIAS) + 18'(n_r[53]);

      // subnormal path: shift right by at least twelve, clamp far shifts
      sh_full = -top - 18'(e80b64_pkg::SUB_OFFSET);
      sh      = (sh_full > 18'sd127) ? 7'd127 : sh_full[6:0];
      wide    = {norm, 64'd0} >> sh;
      s_inc   = wide[63] && ((|wide[62:0]) || wide[64]);
      s_r     = wide[127:64] + 64'(s_inc);

      if (sig_ff == 64'd0) begin
         dbl_in = {sgn, 63'd0};
      end else if (se_ff[14:0] == e80b64_pkg::EXP_TOP) begin
         dbl_in = {sgn, e80b64_pkg::INF_MAG};
      end else if (top > 18'(e80b64_pkg::DBL_EMAX)) begin
         dbl_in = {sgn, e80b64_pkg::INF_MAG};
      end else if (top >= 18'(e80b64_pkg::DBL_EMIN)) begin
         if (biased >= 18'sd2047) begin
            dbl_in = {sgn, e80b64_pkg::INF_MAG};
         end else begin
            // a carry out leaves the fraction at zero
            dbl_in = {sgn, biased[10:0], n_r[53] ? 52'd0 : n_r[51:0]};
         end
      end else begin
         dbl_in = {sgn, s_r[62:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (!req_stall) begin
         sig_ff <= req_significand;
         se_ff  <= req_sign_exponent;
      end
      if (move) begin
         dbl_ff <= dbl_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_double_bits = dbl_ff;

`ifndef NO_ASSERTIONS
   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted word not held in input register");

   a_zero_sig : assert property (@(posedge clock) disable iff (reset)
      (move && sig_ff == 64'd0) |=> (rsp_double_bits[62:0] == 63'd0))
      else $error("zero significand did not give signed zero");

   a_top_exp : assert property (@(posedge clock) disable iff (reset)
      (move && sig_ff != 64'd0 && se_ff[14:0] == e80b64_pkg::EXP_TOP)
      |=> (rsp_double_bits[62:0] == e80b64_pkg::INF_MAG))
      else $error("top exponent did not give infinity");

   a_sign_kept : assert property (@(posedge clock) disable iff (reset)
      move |=> (rsp_double_bits[63] == $past(se_ff[15])))
      else $error("sign lost");
`endif

endmodule
